FILE: rtl/core/lsis_pkg.sv
// lsis_pkg: shared constants, types and saturating helpers for the linear system solver
// no dependencies; used by every module under rtl/core
package lsis_pkg;

    localparam int ORDER  = 4;
    localparam int COLS   = ORDER + 1;
    localparam int CELLS  = ORDER * COLS;
    localparam int VW     = 48;
    localparam int FRAC   = 32;
    localparam int MH     = VW / 2;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(ORDER);
    localparam int COL_W  = $clog2(COLS);
    localparam int TOL_W  = 33;
    localparam int CAP_W  = 16;
    localparam int CFG_W  = 33;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4295);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1000);

    localparam logic REG_TOL = 1'b0;
    localparam logic REG_CAP = 1'b1;

    typedef logic signed [VW-1:0] t_val;

    localparam t_val VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_CONV = 2'd0,
        ST_ZPIV = 2'd1,
        ST_CAP  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_LOAD, S_CP_RD, S_CP_WR,
        S_PV_RD, S_PV_CHK, S_NM_RD, S_NM_GO, S_NM_WT,
        S_FC_RD, S_FC_GET, S_PR_RD, S_PR_GO, S_PR_WT, S_SUB,
        S_RH_RD, S_RH_GET, S_JA_RD, S_JA_GO, S_JA_WT, S_JB_RD, S_JB_GET, S_JCHK,
        S_RS_RD, S_RS_GET, S_RA_RD, S_RA_GO, S_RA_WT, S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        t_val a;
        t_val b;
    } t_op_req;

    function automatic t_val sat_add(t_val a, t_val b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic t_val sat_sub(t_val a, t_val b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] mag_of(t_val x);
        logic [VW-1:0] u;
        u = x;
        if (u[VW-1]) u = ~u + 1'b1;
        return u;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [COL_W-1:0] r, logic [COL_W-1:0] c);
        int t;
        t = int'(r) * COLS + int'(c);
        return t[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/core/lsis_mul.sv
// lsis_mul: sequential saturating Q16.32 multiplier, four half-width partial products
// depends on lsis_pkg
module lsis_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsis_pkg::t_op_req i_req,
    output logic             o_done,
    output lsis_pkg::t_val   o_res
);

    logic [lsis_pkg::VW-1:0]   r_ma, r_mb;
    logic                      r_neg;
    logic [2*lsis_pkg::VW-1:0] r_acc;
    logic [1:0]                r_step;
    logic                      r_busy, r_fin, r_done;
    lsis_pkg::t_val            r_res;

    logic [lsis_pkg::MH-1:0]   pa, pb;
    logic [lsis_pkg::VW-1:0]   pp;
    logic [2*lsis_pkg::VW-1:0] pp_ext;
    logic [lsis_pkg::VW-2:0]   mag;
    logic                      over;
    lsis_pkg::t_val            m_val, fin_val;

    always_comb begin
        pa     = r_step[1] ? r_ma[lsis_pkg::VW-1:lsis_pkg::MH] : r_ma[lsis_pkg::MH-1:0];
        pb     = r_step[0] ? r_mb[lsis_pkg::VW-1:lsis_pkg::MH] : r_mb[lsis_pkg::MH-1:0];
        pp     = pa * pb;
        pp_ext = {{lsis_pkg::VW{1'b0}}, pp}
                 << (lsis_pkg::MH * (int'(r_step[1]) + int'(r_step[0])));
        // product bits at or above 2^47 after the fraction shift mean overflow
        over    = |r_acc[2*lsis_pkg::VW-1:lsis_pkg::FRAC+lsis_pkg::VW-1];
        mag     = r_acc[lsis_pkg::FRAC+lsis_pkg::VW-2:lsis_pkg::FRAC];
        m_val   = {1'b0, mag};
        if (over) fin_val = r_neg ? lsis_pkg::VMIN : lsis_pkg::VMAX;
        else      fin_val = r_neg ? -m_val : m_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= lsis_pkg::mag_of(i_req.a);
            r_mb  <= lsis_pkg::mag_of(i_req.b);
            r_neg <= i_req.a[lsis_pkg::VW-1] != i_req.b[lsis_pkg::VW-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_ext;
        end
        if (r_fin) r_res <= fin_val;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: rtl/core/lsis_div.sv
// lsis_div: restoring divider, one quotient bit per cycle, saturating Q16.32 quotient
// depends on lsis_pkg
module lsis_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsis_pkg::t_op_req i_req,
    output logic             o_done,
    output lsis_pkg::t_val   o_res
);

    localparam int DW = lsis_pkg::VW + lsis_pkg::FRAC;
    localparam int CW = $clog2(DW);

    logic [DW-1:0]           r_dvd;
    logic [lsis_pkg::VW-1:0] r_rem, r_dsr, r_q;
    logic                    r_over, r_neg;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy, r_fin, r_done;
    lsis_pkg::t_val          r_res;

    logic [lsis_pkg::VW:0]   rem2, rem_n;
    logic                    ge;
    lsis_pkg::t_val          q_val, fin_val;

    always_comb begin
        rem2  = {r_rem, r_dvd[DW-1]};
        ge    = rem2 >= {1'b0, r_dsr};
        rem_n = ge ? rem2 - {1'b0, r_dsr} : rem2;
        q_val = r_q;
        if (r_over || r_q[lsis_pkg::VW-1]) fin_val = r_neg ? lsis_pkg::VMIN : lsis_pkg::VMAX;
        else                               fin_val = r_neg ? -q_val : q_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= {lsis_pkg::mag_of(i_req.a), {lsis_pkg::FRAC{1'b0}}};
            r_dsr  <= lsis_pkg::mag_of(i_req.b);
            r_neg  <= i_req.a[lsis_pkg::VW-1] != i_req.b[lsis_pkg::VW-1];
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= rem_n[lsis_pkg::VW-1:0];
            r_dvd  <= r_dvd << 1;
            r_q    <= {r_q[lsis_pkg::VW-2:0], ge};
            // sticky: a quotient bit leaving the register means saturation
            r_over <= r_over | r_q[lsis_pkg::VW-1];
        end
        if (r_fin) r_res <= fin_val;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: rtl/core/linear_system_iterative_solver.sv
// linear_system_iterative_solver: matrix stores, sequencer, elimination and jacobi iteration
// depends on lsis_pkg, lsis_mul, lsis_div
// after the last word the matrix is copied, then eliminated with 14 divides and 26 products
// (a zero pivot skips to the results), then jacobi iterations run, then the result rows are
// computed; one word loads per cycle while o_stall is low, the next run waits for all results
// all dependent steps go through one shared multiplier and one shared divider
// reset (synchronous, active low) restores tolerance and cap and clears vectors; matrices
// hold stale data until written
module linear_system_iterative_solver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_row,
    input  logic [3:0]                    i_col,
    input  logic signed [lsis_pkg::VW-1:0] i_value,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_index,
    output logic signed [lsis_pkg::VW-1:0] o_solution,
    output logic signed [lsis_pkg::VW-1:0] o_residual,
    output logic [lsis_pkg::CAP_W-1:0]    o_iterations,
    output logic [1:0]                    o_status,
    output logic                          o_final_res,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [lsis_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int LAST_I = lsis_pkg::ORDER - 1;

    lsis_pkg::t_state r_state, n_state;

    logic [lsis_pkg::TOL_W-1:0] r_tol;
    logic [lsis_pkg::CAP_W-1:0] r_cap;
    logic [lsis_pkg::CAP_W-1:0] r_iter;
    lsis_pkg::t_status          r_status;

    logic [lsis_pkg::IDX_W-1:0]  r_i, r_j;
    logic [lsis_pkg::COL_W-1:0]  r_k;
    logic [lsis_pkg::ADDR_W-1:0] r_cnt;
    lsis_pkg::t_val r_p, r_f, r_s, r_prev;
    lsis_pkg::t_val r_cur [lsis_pkg::ORDER];
    lsis_pkg::t_val r_nxt [lsis_pkg::ORDER];

    lsis_pkg::t_val r_orig_mem [lsis_pkg::CELLS];
    lsis_pkg::t_val r_work_mem [lsis_pkg::CELLS];
    lsis_pkg::t_val r_orig_q, r_work_q;

    logic                    r_ov;
    logic [2:0]              r_o_index;
    lsis_pkg::t_val          r_o_sol, r_o_res;
    logic [lsis_pkg::CAP_W-1:0] r_o_iter;
    lsis_pkg::t_status       r_o_status;
    logic                    r_o_final;

    logic                        in_acc, in_range, out_free;
    logic                        orig_we, work_we;
    logic [lsis_pkg::ADDR_W-1:0] orig_wa, orig_ra, work_wa, work_ra;
    lsis_pkg::t_val              work_wd;
    lsis_pkg::t_op_req           mul_req, div_req;
    logic                        mul_done, div_done;
    lsis_pkg::t_val              mul_res, div_res;

    logic [lsis_pkg::COL_W-1:0]  ci, cj;
    logic                        k_at_i, i_last_row, j_last_row;
    logic [lsis_pkg::CAP_W-1:0]  iter_new, cap_eff;
    logic                        conv, capped;

    lsis_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_done (mul_done),
        .o_res  (mul_res)
    );

    lsis_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_res  (div_res)
    );

    assign o_stall  = (r_state != lsis_pkg::S_LOAD);
    assign in_acc   = i_valid && !o_stall;
    assign in_range = (i_row < 3'(lsis_pkg::ORDER)) && (i_col <= 4'(lsis_pkg::ORDER));
    assign out_free = !r_ov || !i_stall;

    assign ci         = lsis_pkg::COL_W'(r_i);
    assign cj         = lsis_pkg::COL_W'(r_j);
    assign k_at_i     = (r_k == ci);
    assign i_last_row = (r_i == lsis_pkg::IDX_W'(LAST_I));
    assign j_last_row = (r_j == lsis_pkg::IDX_W'(LAST_I));

    assign iter_new = r_iter + 1'b1;
    assign cap_eff  = (r_cap == '0) ? lsis_pkg::CAP_W'(1) : r_cap;
    assign conv     = (iter_new >= lsis_pkg::CAP_W'(2)) &&
                      (lsis_pkg::mag_of(lsis_pkg::sat_sub(r_prev, r_nxt[LAST_I]))
                       < lsis_pkg::VW'(r_tol));
    assign capped   = (iter_new >= cap_eff);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= lsis_pkg::TOL_RESET;
            r_cap <= lsis_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lsis_pkg::REG_TOL: r_tol <= i_cfg_data[lsis_pkg::TOL_W-1:0];
                lsis_pkg::REG_CAP: r_cap <= i_cfg_data[lsis_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // memories: registered read every cycle; in S_SUB the read addresses the entry written on
    // the same edge and so returns its old value
    always_ff @(posedge i_clk) begin
        if (orig_we) r_orig_mem[orig_wa] <= i_value;
        r_orig_q <= r_orig_mem[orig_ra];
    end

    always_ff @(posedge i_clk) begin
        if (work_we) r_work_mem[work_wa] <= work_wd;
        r_work_q <= r_work_mem[work_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsis_pkg::S_LOAD:   if (in_acc && i_last) n_state = lsis_pkg::S_CP_RD;
            lsis_pkg::S_CP_RD:  n_state = lsis_pkg::S_CP_WR;
            lsis_pkg::S_CP_WR:  n_state = (r_cnt == lsis_pkg::ADDR_W'(lsis_pkg::CELLS - 1))
                                          ? lsis_pkg::S_PV_RD : lsis_pkg::S_CP_RD;
            lsis_pkg::S_PV_RD:  n_state = lsis_pkg::S_PV_CHK;
            lsis_pkg::S_PV_CHK: n_state = (r_work_q == '0) ? lsis_pkg::S_RS_RD
                                                           : lsis_pkg::S_NM_RD;
            lsis_pkg::S_NM_RD:  n_state = lsis_pkg::S_NM_GO;
            lsis_pkg::S_NM_GO:  n_state = lsis_pkg::S_NM_WT;
            lsis_pkg::S_NM_WT: begin
                if (div_done) begin
                    if (!k_at_i)        n_state = lsis_pkg::S_NM_RD;
                    else if (i_last_row) n_state = lsis_pkg::S_RH_RD;
                    else                n_state = lsis_pkg::S_FC_RD;
                end
            end
            lsis_pkg::S_FC_RD:  n_state = lsis_pkg::S_FC_GET;
            lsis_pkg::S_FC_GET: n_state = lsis_pkg::S_PR_RD;
            lsis_pkg::S_PR_RD:  n_state = lsis_pkg::S_PR_GO;
            lsis_pkg::S_PR_GO:  n_state = lsis_pkg::S_PR_WT;
            lsis_pkg::S_PR_WT:  if (mul_done) n_state = lsis_pkg::S_SUB;
            lsis_pkg::S_SUB: begin
                if (!k_at_i)        n_state = lsis_pkg::S_PR_RD;
                else if (j_last_row) n_state = lsis_pkg::S_PV_RD;
                else                n_state = lsis_pkg::S_FC_RD;
            end
            lsis_pkg::S_RH_RD:  n_state = lsis_pkg::S_RH_GET;
            lsis_pkg::S_RH_GET: n_state = i_last_row ? lsis_pkg::S_JA_RD : lsis_pkg::S_RH_RD;
            lsis_pkg::S_JA_RD: begin
                if (r_j != r_i)     n_state = lsis_pkg::S_JA_GO;
                else if (j_last_row) n_state = lsis_pkg::S_JB_RD;
            end
            lsis_pkg::S_JA_GO:  n_state = lsis_pkg::S_JA_WT;
            lsis_pkg::S_JA_WT: begin
                if (mul_done) n_state = j_last_row ? lsis_pkg::S_JB_RD : lsis_pkg::S_JA_RD;
            end
            lsis_pkg::S_JB_RD:  n_state = lsis_pkg::S_JB_GET;
            lsis_pkg::S_JB_GET: n_state = i_last_row ? lsis_pkg::S_JCHK : lsis_pkg::S_JA_RD;
            lsis_pkg::S_JCHK:   n_state = (conv || capped) ? lsis_pkg::S_RS_RD
                                                           : lsis_pkg::S_JA_RD;
            lsis_pkg::S_RS_RD:  n_state = lsis_pkg::S_RS_GET;
            lsis_pkg::S_RS_GET: n_state = lsis_pkg::S_RA_RD;
            lsis_pkg::S_RA_RD:  n_state = lsis_pkg::S_RA_GO;
            lsis_pkg::S_RA_GO:  n_state = lsis_pkg::S_RA_WT;
            lsis_pkg::S_RA_WT: begin
                if (mul_done) n_state = j_last_row ? lsis_pkg::S_EMIT : lsis_pkg::S_RA_RD;
            end
            lsis_pkg::S_EMIT: begin
                if (out_free) n_state = i_last_row ? lsis_pkg::S_LOAD : lsis_pkg::S_RS_RD;
            end
            default:            n_state = lsis_pkg::S_LOAD;
        endcase
    end

    // memory ports and unit requests
    always_comb begin
        orig_we = in_acc && in_range;
        orig_wa = lsis_pkg::cell_addr(lsis_pkg::COL_W'(i_row), lsis_pkg::COL_W'(i_col));
        orig_ra = '0;
        work_we = 1'b0;
        work_wa = '0;
        work_wd = r_orig_q;
        work_ra = '0;
        mul_req = '0;
        div_req = '0;
        unique case (r_state)
            lsis_pkg::S_CP_RD:  orig_ra = r_cnt;
            lsis_pkg::S_CP_WR: begin
                work_we = 1'b1;
                work_wa = r_cnt;
            end
            lsis_pkg::S_PV_RD:  work_ra = lsis_pkg::cell_addr(ci, ci);
            lsis_pkg::S_NM_RD:  work_ra = lsis_pkg::cell_addr(ci, r_k);
            lsis_pkg::S_NM_GO: begin
                div_req.start = 1'b1;
                div_req.a     = r_work_q;
                div_req.b     = r_p;
            end
            lsis_pkg::S_NM_WT: begin
                work_we = div_done;
                work_wa = lsis_pkg::cell_addr(ci, r_k);
                work_wd = div_res;
            end
            lsis_pkg::S_FC_RD:  work_ra = lsis_pkg::cell_addr(cj, ci);
            lsis_pkg::S_PR_RD:  work_ra = lsis_pkg::cell_addr(ci, r_k);
            lsis_pkg::S_PR_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_f;
                mul_req.b     = r_work_q;
            end
            lsis_pkg::S_PR_WT:  work_ra = lsis_pkg::cell_addr(cj, r_k);
            lsis_pkg::S_SUB: begin
                work_ra = lsis_pkg::cell_addr(cj, r_k);
                work_we = 1'b1;
                work_wa = lsis_pkg::cell_addr(cj, r_k);
                work_wd = lsis_pkg::sat_sub(r_work_q, mul_res);
            end
            lsis_pkg::S_RH_RD:  work_ra = lsis_pkg::cell_addr(ci, lsis_pkg::COL_W'(lsis_pkg::ORDER));
            lsis_pkg::S_JA_RD:  work_ra = lsis_pkg::cell_addr(ci, cj);
            lsis_pkg::S_JA_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_work_q;
                mul_req.b     = r_cur[r_j];
            end
            lsis_pkg::S_JB_RD:  work_ra = lsis_pkg::cell_addr(ci, lsis_pkg::COL_W'(lsis_pkg::ORDER));
            lsis_pkg::S_RS_RD:  orig_ra = lsis_pkg::cell_addr(ci, lsis_pkg::COL_W'(lsis_pkg::ORDER));
            lsis_pkg::S_RA_RD:  orig_ra = lsis_pkg::cell_addr(ci, cj);
            lsis_pkg::S_RA_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_orig_q;
                mul_req.b     = r_nxt[r_j];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lsis_pkg::S_LOAD;
        else          r_state <= n_state;
    end

    // sequencer counters, vectors and run status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_iter   <= '0;
            r_prev   <= '0;
            r_status <= lsis_pkg::ST_CONV;
            for (int n = 0; n < lsis_pkg::ORDER; n++) begin
                r_cur[n] <= '0;
                r_nxt[n] <= '0;
            end
        end else begin
            unique case (r_state)
                lsis_pkg::S_LOAD: begin
                    if (in_acc && i_last) begin
                        r_cnt  <= '0;
                        r_iter <= '0;
                    end
                end
                lsis_pkg::S_CP_WR: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_i   <= '0;
                end
                lsis_pkg::S_PV_CHK: begin
                    if (r_work_q == '0) begin
                        // zero pivot: report rhs as residual with a zero solution
                        r_status <= lsis_pkg::ST_ZPIV;
                        r_prev   <= '0;
                        r_i      <= '0;
                        for (int n = 0; n < lsis_pkg::ORDER; n++) begin
                            r_cur[n] <= '0;
                            r_nxt[n] <= '0;
                        end
                    end else begin
                        r_p <= r_work_q;
                        r_k <= lsis_pkg::COL_W'(lsis_pkg::ORDER);
                    end
                end
                lsis_pkg::S_NM_WT: begin
                    if (div_done) begin
                        if (!k_at_i) begin
                            r_k <= r_k - 1'b1;
                        end else begin
                            r_j <= r_i + 1'b1;
                            if (i_last_row) r_i <= '0;
                        end
                    end
                end
                lsis_pkg::S_FC_GET: begin
                    r_f <= r_work_q;
                    r_k <= lsis_pkg::COL_W'(lsis_pkg::ORDER);
                end
                lsis_pkg::S_SUB: begin
                    if (!k_at_i)        r_k <= r_k - 1'b1;
                    else if (j_last_row) r_i <= r_i + 1'b1;
                    else                r_j <= r_j + 1'b1;
                end
                lsis_pkg::S_RH_GET: begin
                    r_cur[r_i] <= r_work_q;
                    r_i        <= i_last_row ? '0 : r_i + 1'b1;
                    r_j        <= '0;
                    r_s        <= '0;
                end
                lsis_pkg::S_JA_RD: begin
                    if (r_j == r_i && !j_last_row) r_j <= r_j + 1'b1;
                end
                lsis_pkg::S_JA_WT: begin
                    if (mul_done) begin
                        r_s <= lsis_pkg::sat_sub(r_s, mul_res);
                        if (!j_last_row) r_j <= r_j + 1'b1;
                    end
                end
                lsis_pkg::S_JB_GET: begin
                    r_nxt[r_i] <= lsis_pkg::sat_add(r_s, r_work_q);
                    r_s        <= '0;
                    r_j        <= '0;
                    r_i        <= i_last_row ? '0 : r_i + 1'b1;
                end
                lsis_pkg::S_JCHK: begin
                    r_iter   <= iter_new;
                    r_prev   <= r_nxt[LAST_I];
                    r_status <= conv ? lsis_pkg::ST_CONV : lsis_pkg::ST_CAP;
                    for (int n = 0; n < lsis_pkg::ORDER; n++) r_cur[n] <= r_nxt[n];
                end
                lsis_pkg::S_RS_GET: begin
                    r_s <= r_orig_q;
                    r_j <= '0;
                end
                lsis_pkg::S_RA_WT: begin
                    if (mul_done) begin
                        r_s <= lsis_pkg::sat_sub(r_s, mul_res);
                        if (!j_last_row) r_j <= r_j + 1'b1;
                    end
                end
                lsis_pkg::S_EMIT: begin
                    if (out_free) r_i <= i_last_row ? '0 : r_i + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == lsis_pkg::S_EMIT && out_free) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lsis_pkg::S_EMIT && out_free) begin
            r_o_index  <= 3'(r_i);
            r_o_sol    <= r_nxt[r_i];
            r_o_res    <= r_s;
            r_o_iter   <= r_iter;
            r_o_status <= r_status;
            r_o_final  <= i_last_row;
        end
    end

    assign o_valid      = r_ov;
    assign o_index      = r_o_index;
    assign o_solution   = r_o_sol;
    assign o_residual   = r_o_res;
    assign o_iterations = r_o_iter;
    assign o_status     = r_o_status;
    assign o_final_res  = r_o_final;

endmodule

FILE: rtl/core/lsis_chk.sv
// lsis_chk: port-level checks on the result channel of the solver
// depends on lsis_pkg; bound to linear_system_iterative_solver below
module lsis_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [2:0]                    o_index,
    input logic signed [lsis_pkg::VW-1:0] o_solution,
    input logic [lsis_pkg::CAP_W-1:0]    o_iterations,
    input logic [1:0]                    o_status,
    input logic                          o_final_res
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    a_zpiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == lsis_pkg::ST_ZPIV |-> o_iterations == '0 && o_solution == '0)
        else $error("zero pivot word carries iterations or a solution");

    a_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == lsis_pkg::ST_CONV |-> o_iterations >= lsis_pkg::CAP_W'(2))
        else $error("converged after fewer than two iterations");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == lsis_pkg::ST_CAP |-> o_iterations != '0)
        else $error("cap status with no iteration");

    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_final_res |-> o_index == 3'(lsis_pkg::ORDER - 1))
        else $error("final word not on last row");

endmodule

bind linear_system_iterative_solver lsis_chk u_lsis_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_index     (o_index),
    .o_solution  (o_solution),
    .o_iterations(o_iterations),
    .o_status    (o_status),
    .o_final_res (o_final_res)
);
